@@ rtl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

  // Timestamp width; differences wrap modulo 2**TIME_BITS
  localparam int unsigned TIME_BITS = 32;
  // Limit register width
  localparam int unsigned LIMIT_W = 16;
  // Width for compares against double_limit + 2 (needs LIMIT_W + 1 bits)
  localparam int unsigned CMP_W = (TIME_BITS > LIMIT_W + 1) ? TIME_BITS : LIMIT_W + 1;

  // Configuration port widths and register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_LIMIT = 8'd1;

  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd100;
  localparam logic [LIMIT_W-1:0] DOUBLE_LIMIT_RST = 16'd30;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_SINGLE = 2'd1,
    CLASS_DOUBLE = 2'd2,
    CLASS_LONG   = 2'd3
  } press_class_e;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_UP   = 2'd1,
    EDGE_DOWN = 2'd2
  } edge_e;

  // Detector state carried from one sample to the next
  typedef struct packed {
    logic                 cur_level;
    edge_e                last_edge;
    logic                 pending;
    press_class_e         press_class;
    logic [TIME_BITS-1:0] up1;
    logic [TIME_BITS-1:0] down0;
    logic [TIME_BITS-1:0] down1;
  } bpc_state_t;

  // Stream payload widths: input is level plus timestamp, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = ((TIME_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 8;

endpackage

`default_nettype wire

@@ rtl/bpc_rules.sv @@
`default_nettype none

// Next-state logic: edge update followed by the four classification rules
module bpc_rules (
  input  var bpc_pkg::bpc_state_t             state_i,
  input  wire logic                           level_i,
  input  wire logic [bpc_pkg::TIME_BITS-1:0]  now_ticks_i,
  input  wire logic [bpc_pkg::LIMIT_W-1:0]    long_limit_i,
  input  wire logic [bpc_pkg::LIMIT_W-1:0]    double_limit_i,
  output bpc_pkg::bpc_state_t                 state_o
);

  logic                          rise, fall;
  logic [bpc_pkg::TIME_BITS-1:0] u1, d0, d1;
  logic [bpc_pkg::TIME_BITS-1:0] d1_u1, t_d1, u1_d0, t_u1, u1_d1;
  logic [bpc_pkg::CMP_W-1:0]     lim_l, lim_d, lim_d2;
  logic [bpc_pkg::CMP_W-1:0]     x_d1_u1, x_t_d1, x_u1_d0, x_t_u1, x_u1_d1;
  logic                          pend1, pend2, hit_single, hit_double, hit_long;

  // Edge detection against the stored sample
  assign rise = ~state_i.cur_level & level_i;
  assign fall = state_i.cur_level & ~level_i;

  assign u1 = rise ? now_ticks_i : state_i.up1;
  assign d0 = fall ? state_i.down1 : state_i.down0;
  assign d1 = fall ? now_ticks_i : state_i.down1;

  // Wrapping differences
  assign d1_u1 = d1 - u1;
  assign t_d1  = now_ticks_i - d1;
  assign u1_d0 = u1 - d0;
  assign t_u1  = now_ticks_i - u1;
  assign u1_d1 = u1 - d1;

  // Zero-extend everything to a common compare width
  assign lim_l   = bpc_pkg::CMP_W'(long_limit_i);
  assign lim_d   = bpc_pkg::CMP_W'(double_limit_i);
  assign lim_d2  = lim_d + bpc_pkg::CMP_W'(2);
  assign x_d1_u1 = bpc_pkg::CMP_W'(d1_u1);
  assign x_t_d1  = bpc_pkg::CMP_W'(t_d1);
  assign x_u1_d0 = bpc_pkg::CMP_W'(u1_d0);
  assign x_t_u1  = bpc_pkg::CMP_W'(t_u1);
  assign x_u1_d1 = bpc_pkg::CMP_W'(u1_d1);

  // Short press seen: release follows press within the long limit
  assign pend1 = state_i.pending | ((d1 > u1) && (x_d1_u1 <= lim_l));

  assign hit_single = pend1 && (x_t_d1 > lim_d) && (u1 < d1) &&
                      (x_u1_d0 > lim_d) && (x_t_d1 < lim_d2);
  assign pend2      = pend1 & ~hit_single;
  assign hit_double = pend2 && (x_t_d1 < lim_d) && (u1 > d1);
  assign hit_long   = (x_t_u1 > lim_l) && (u1 > d1) && (x_u1_d1 > lim_d);

  // Later rules override earlier ones
  always_comb begin
    state_o           = state_i;
    state_o.cur_level = level_i;
    state_o.up1       = u1;
    state_o.down0     = d0;
    state_o.down1     = d1;
    if (rise) begin
      state_o.last_edge = bpc_pkg::EDGE_UP;
    end
    if (fall) begin
      state_o.last_edge = bpc_pkg::EDGE_DOWN;
    end
    state_o.pending = pend1;
    if (hit_single) begin
      state_o.press_class = bpc_pkg::CLASS_SINGLE;
      state_o.pending     = 1'b0;
    end
    if (hit_double) begin
      state_o.press_class = bpc_pkg::CLASS_DOUBLE;
      state_o.pending     = 1'b0;
    end
    if (hit_long) begin
      state_o.press_class = bpc_pkg::CLASS_LONG;
      state_o.pending     = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/button_press_classifier_top.sv @@
`default_nettype none

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_tvalid_i / s_tready_o    level, now_ticks
// m_axis    out        m_tvalid_o / m_tready_i    press_class, last_edge, pulse_pending
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One sample per cycle while results are taken; each result appears in the cycle after its request is taken.
// Data path: state register and incoming request -> rule logic (32-bit subtracts
// and compares) -> state and result registers.
// s_tready_o drops only while a result waits and m_tready_i is low (combinational).
// Reset (rst_ni low) restores the limits 100 / 30 and all state but the result data.
// Configuration writes are always taken.
module button_press_classifier_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  // [0] level, [32:1] now_ticks, [39:33] zero
  input  wire logic [bpc_pkg::IN_DATA_W-1:0]    s_tdata_i,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  // [1:0] press_class, [3:2] last_edge, [4] pulse_pending, [7:5] zero
  output logic [bpc_pkg::OUT_DATA_W-1:0]        m_tdata_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [bpc_pkg::LIMIT_W-1:0] long_limit_q, double_limit_q;
  bpc_pkg::bpc_state_t         state_q, state_d;
  logic                        out_valid_q;
  logic [bpc_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                        in_fire;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = ~out_valid_q | m_tready_i;
  assign in_fire     = s_tvalid_i & s_tready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_limit_q   <= bpc_pkg::LONG_LIMIT_RST;
      double_limit_q <= bpc_pkg::DOUBLE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bpc_pkg::REG_LONG_LIMIT) begin
        long_limit_q <= cfg_data_i[bpc_pkg::LIMIT_W-1:0];
      end
      if (cfg_index_i == bpc_pkg::REG_DOUBLE_LIMIT) begin
        double_limit_q <= cfg_data_i[bpc_pkg::LIMIT_W-1:0];
      end
    end
  end

  bpc_rules u_rules (
    .state_i        (state_q),
    .level_i        (s_tdata_i[0]),
    .now_ticks_i    (s_tdata_i[bpc_pkg::TIME_BITS:1]),
    .long_limit_i   (long_limit_q),
    .double_limit_i (double_limit_q),
    .state_o        (state_d)
  );

  // Detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{cur_level: 1'b0, last_edge: bpc_pkg::EDGE_NONE, pending: 1'b0,
                   press_class: bpc_pkg::CLASS_NONE, up1: '0, down0: '0, down1: '0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {3'b000, state_d.pending, state_d.last_edge, state_d.press_class};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // Class never returns to none once set
  a_class_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.press_class != bpc_pkg::CLASS_NONE |=> state_q.press_class != bpc_pkg::CLASS_NONE)
    else $error("press class fell back to none");

  // Any class change clears the pending flag
  a_class_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.press_class != $past(state_q.press_class) |-> !state_q.pending)
    else $error("pending still set after classification");

  // Every accepted request yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_tvalid_o)
    else $error("accepted request produced no result");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (m_tvalid_o && !m_tready_i))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

@@ dv/button_press_classifier_top_test.sv @@
`default_nettype none

module button_press_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  // Index that maps to no register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;
  localparam int unsigned PAD_W = IN_DATA_W - TIME_BITS - 1;

  typedef logic [TIME_BITS-1:0] ticks_t;

  // One expected result as it appears on m_tdata_o
  typedef struct packed {
    logic         pend;
    edge_e        edg;
    press_class_e cls;
  } press_result_t;

  // Press classifier model plus the queue of results still owed by the block
  class press_scoreboard;
    logic [LIMIT_W-1:0] long_lim;
    logic [LIMIT_W-1:0] dbl_lim;
    logic               prev_lvl;
    logic               cur_lvl;
    edge_e              last_edge;
    logic               pend;
    press_class_e       cls;
    ticks_t             up_t[2];
    ticks_t             down_t[2];
    press_result_t      owed_q[$];
    int                 errors;

    function new();
      long_lim  = LONG_LIMIT_RST;
      dbl_lim   = DOUBLE_LIMIT_RST;
      prev_lvl  = 1'b0;
      cur_lvl   = 1'b0;
      last_edge = EDGE_NONE;
      pend      = 1'b0;
      cls       = CLASS_NONE;
      up_t[0]   = '0;
      up_t[1]   = '0;
      down_t[0] = '0;
      down_t[1] = '0;
      errors    = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_LONG_LIMIT) begin
        long_lim = val[LIMIT_W-1:0];
      end else if (idx == REG_DOUBLE_LIMIT) begin
        dbl_lim = val[LIMIT_W-1:0];
      end
    endfunction

    // Edge update, then the four rules in order (later ones win)
    function void note_sample(logic lvl, ticks_t t);
      ticks_t        u1, d0, d1;
      ticks_t        lim_l, lim_d;
      press_result_t res;
      prev_lvl = cur_lvl;
      cur_lvl  = lvl;
      if (!prev_lvl && cur_lvl) begin
        last_edge = EDGE_UP;
        up_t[0]   = up_t[1];
        up_t[1]   = t;
      end
      if (prev_lvl && !cur_lvl) begin
        last_edge = EDGE_DOWN;
        down_t[0] = down_t[1];
        down_t[1] = t;
      end
      u1    = up_t[1];
      d0    = down_t[0];
      d1    = down_t[1];
      lim_l = ticks_t'(long_lim);
      lim_d = ticks_t'(dbl_lim);

      // short press just released
      if (d1 > u1 && ticks_t'(d1 - u1) <= lim_l) pend = 1'b1;
      // quiet window after release closed: single
      if (pend && ticks_t'(t - d1) > lim_d && u1 < d1 && ticks_t'(u1 - d0) > lim_d &&
          ticks_t'(t - d1) < lim_d + 2) begin
        cls  = CLASS_SINGLE;
        pend = 1'b0;
      end
      // pressed again soon after release: double
      if (pend && ticks_t'(t - d1) < lim_d && u1 > d1) begin
        cls  = CLASS_DOUBLE;
        pend = 1'b0;
      end
      // held down past the long limit
      if (ticks_t'(t - u1) > lim_l && u1 > d1 && ticks_t'(u1 - d1) > lim_d) begin
        cls  = CLASS_LONG;
        pend = 1'b0;
      end

      res.cls  = cls;
      res.edg  = last_edge;
      res.pend = pend;
      owed_q.push_back(res);
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      press_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("unrequested result", int'(data), -1);
      end else begin
        want = owed_q.pop_front();
        if (data[1:0] != want.cls) begin
          report_mismatch("press_class", int'(data[1:0]), int'(want.cls));
        end
        if (data[3:2] != want.edg) begin
          report_mismatch("last_edge", int'(data[3:2]), int'(want.edg));
        end
        if (data[4] != want.pend) begin
          report_mismatch("pulse_pending", int'(data[4]), int'(want.pend));
        end
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i;
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [OUT_DATA_W-1:0] m_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  press_scoreboard sb;
  bit              gaps_on;
  int              rx_hold;
  ticks_t          tick_now;
  logic            lvl_now;

  button_press_classifier_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Sample request; valid stays up on return so a back-to-back request needs no dip
  task automatic send_sample(input logic lvl, input ticks_t t);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {{PAD_W{1'b0}}, t, lvl};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_sample(lvl, t);
  endtask

  // Stop sending and wait for every owed result, then let the pipe settle
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(idx, val);
  endtask

  // Button activity: alternating level runs with small tick steps, some noise
  task automatic press_stream(input int n, input int unsigned max_step,
                              input int unsigned long_l, input int unsigned dbl_l);
    int          cnt;
    int unsigned run_max;
    int unsigned run;
    cnt     = 0;
    run_max = (2 * long_l + dbl_l + 8) / (max_step / 2 + 1) + 1;
    if (run_max > 120) run_max = 120;
    while (cnt < n) begin
      if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
      lvl_now = !lvl_now;
      run = $urandom_range(1, run_max);
      for (int i = 0; i < run && cnt < n; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_sample(1'($urandom_range(0, 1)), ticks_t'($urandom()));
        end else begin
          tick_now = tick_now + $urandom_range(0, max_step);
          send_sample(lvl_now, tick_now);
        end
        cnt++;
      end
    end
  endtask

  // New limits while idle, then a burst of presses
  task automatic run_phase(input int unsigned long_l, input int unsigned dbl_l,
                           input int unsigned max_step, input int n, input int hold);
    drain_results();
    write_reg(REG_LONG_LIMIT, {16'($urandom()), 16'(long_l)});
    write_reg(REG_DOUBLE_LIMIT, {16'($urandom()), 16'(dbl_l)});
    cfg_valid_i <= 1'b0;
    rx_hold = hold;
    press_stream(n, max_step, long_l, dbl_l);
  endtask

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, 9) : 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      sb.check_result(m_tdata_o);
    end
  end

  // Watchdog
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int tail;
    sb          = new();
    gaps_on     = 1'b1;
    rx_hold     = 0;
    tick_now    = '0;
    lvl_now     = 1'b0;
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    m_tready_i  = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset limits (long 100, double 30): single, double, long, wrap
    send_sample(1'b0, 32'd0);
    send_sample(1'b1, 32'd100);
    send_sample(1'b0, 32'd140);
    send_sample(1'b0, 32'd171);
    send_sample(1'b1, 32'd200);
    send_sample(1'b0, 32'd210);
    send_sample(1'b1, 32'd220);
    send_sample(1'b0, 32'd230);
    send_sample(1'b1, 32'd300);
    send_sample(1'b1, 32'd401);
    send_sample(1'b1, 32'd500);
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0005);
    send_sample(1'b0, 32'h0000_0010);
    send_sample(1'b0, 32'h0000_0030);
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);

    // Random part under several limit settings
    tick_now = 32'd1000;
    press_stream(250, 4, 32'(LONG_LIMIT_RST), 32'(DOUBLE_LIMIT_RST));
    run_phase(20, 5, 1, 300, 60);
    run_phase(0, 0, 1, 150, 0);

    // Widest limits; a write to an unknown index must change nothing
    drain_results();
    write_reg(REG_UNUSED, 32'h0000_0007);
    write_reg(8'($urandom_range(2, 254)), $urandom());
    cfg_valid_i <= 1'b0;
    tick_now = 32'hFFFF_0000;
    run_phase(65535, 65535, 8000, 200, 0);

    tick_now = 32'hFFFF_FF00;
    run_phase(8, 2, 1, 300, 80);
    run_phase($urandom_range(1, 200), $urandom_range(0, 60), 3, 250, 0);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535), 2000, 150, 0);

    // Drain, then watch for anything spurious
    s_tvalid_i <= 1'b0;
    tail = 0;
    while (sb.outstanding() != 0 && tail < 5000) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (5) @(posedge clk_i);
    if (sb.outstanding() != 0) sb.report_mismatch("results never delivered", 0, sb.outstanding());

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
